// File: hdl/cdh_pkg.sv
// Shared types and constants for the chained hash dictionary.
// Holds operation and status codes, the request record and default sizes.
// No dependencies.
package cdh_pkg;

  localparam int unsigned DefBuckets   = 10;
  localparam int unsigned DefPoolSlots = 64;
  localparam int unsigned BktW         = 6;

  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;

  localparam logic [1:0] StDone = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // ceil(2^35 / 10): quotient by 10 is (x * Recip10) >> 35 for any 32-bit x
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [1:0]      func;
    logic [31:0]     key;
    logic [31:0]     value;
    logic [BktW-1:0] bkt;
  } req_t;

endpackage

// File: hdl/cdh_front.sv
// Front end: accepts a request and computes its bucket from the key digit sum.
// One decimal digit per cycle, then a subtract loop for the modulo.
// Depends on cdh_pkg.
module cdh_front #(
  parameter int unsigned Buckets = cdh_pkg::DefBuckets
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    func_i,
  input  logic [31:0]   key_i,
  input  logic [31:0]   value_i,
  output logic          busy_o,
  input  logic          full_i,
  output logic          push_o,
  output cdh_pkg::req_t req_o
);
  import cdh_pkg::*;

  localparam logic [6:0] BktLim = 7'(Buckets);

  typedef enum logic [3:0] {
    FIdle = 4'b0001,
    FDig  = 4'b0010,
    FMod  = 4'b0100,
    FPush = 4'b1000
  } fstate_e;

  fstate_e     state_q, state_d;
  logic [1:0]  func_q, func_d;
  logic [31:0] key_q, key_d, value_q, value_d;
  logic [31:0] rem_q, rem_d;
  logic [6:0]  sum_q, sum_d;

  logic [63:0] prod;
  logic [31:0] quo, tmp;
  logic [3:0]  dig;

  assign prod = {32'd0, rem_q} * {32'd0, Recip10};
  assign quo  = {3'b000, prod[63:35]};
  assign tmp  = rem_q - ({quo[28:0], 3'b000} + {quo[30:0], 1'b0});
  assign dig  = tmp[3:0];

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    key_d   = key_q;
    value_d = value_q;
    rem_d   = rem_q;
    sum_d   = sum_q;
    case (state_q)
      FIdle: begin
        if (start_i) begin
          func_d  = func_i;
          key_d   = key_i;
          value_d = value_i;
          // negative keys land in bucket 0
          rem_d   = key_i[31] ? 32'd0 : key_i;
          sum_d   = 7'd0;
          state_d = FDig;
        end
      end
      FDig: begin
        if (rem_q == 32'd0) begin
          state_d = FMod;
        end else begin
          rem_d = quo;
          sum_d = sum_q + {3'b000, dig};
        end
      end
      FMod: begin
        if (sum_q >= BktLim) sum_d = sum_q - BktLim;
        else state_d = FPush;
      end
      FPush: begin
        if (!full_i) state_d = FIdle;
      end
      default: state_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    key_q   <= key_d;
    value_q <= value_d;
    rem_q   <= rem_d;
    sum_q   <= sum_d;
  end

  assign busy_o      = (state_q != FIdle);
  assign push_o      = (state_q == FPush) && !full_i;
  assign req_o.func  = func_q;
  assign req_o.key   = key_q;
  assign req_o.value = value_q;
  assign req_o.bkt   = sum_q[BktW-1:0];

endmodule

// File: hdl/cdh_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on cdh_pkg.
module cdh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cdh_pkg::req_t req_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cdh_pkg::req_t req_o
);
  import cdh_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= req_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign req_o   = mem_q[rd_q];

endmodule

// File: hdl/cdh_back.sv
// Back end: bucket heads, node pool and free list; runs insert, delete, lookup.
// Walks one chain node per cycle out of registered-read memories.
// Depends on cdh_pkg.
module cdh_back #(
  parameter int unsigned Buckets   = cdh_pkg::DefBuckets,
  parameter int unsigned PoolSlots = cdh_pkg::DefPoolSlots
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cdh_pkg::req_t req_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic          found_o,
  output logic [31:0]   read_value_o,
  output logic [3:0]    bucket_o,
  output logic [1:0]    status_o
);
  import cdh_pkg::*;

  localparam int unsigned HW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned SW = $clog2(PoolSlots);
  localparam int unsigned PW = $clog2(PoolSlots + 1);
  localparam logic [PW-1:0] Nil = PW'(PoolSlots);

  typedef enum logic [3:0] {
    BIdle = 4'b0001,
    BHead = 4'b0010,
    BPop  = 4'b0100,
    BWalk = 4'b1000
  } bstate_e;

  bstate_e     state_q, state_d;
  req_t        op_q, op_d;
  logic [PW-1:0] cur_q, cur_d, prev_q, prev_d, step_q, step_d;
  logic [PW-1:0] fcnt_q, fcnt_d, fresh_q, fresh_d;

  logic        res_vld_q, res_vld_d, res_found_q, res_found_d;
  logic [31:0] res_rv_q, res_rv_d;
  logic [1:0]  res_st_q, res_st_d;
  logic [3:0]  res_bkt_q;

  // memories
  logic [PW-1:0] head_mem [Buckets];
  logic [Buckets-1:0] head_vld_q;
  logic [PW-1:0] head_rd_q;
  logic [31:0]   key_mem [PoolSlots];
  logic [31:0]   val_mem [PoolSlots];
  logic [PW-1:0] nxt_mem [PoolSlots];
  logic [31:0]   key_rd_q, val_rd_q;
  logic [PW-1:0] nxt_rd_q;
  logic [SW-1:0] stk_mem [PoolSlots];
  logic [SW-1:0] stk_rd_q;

  logic          head_re, head_we;
  logic [HW-1:0] head_raddr, head_waddr;
  logic [PW-1:0] head_wdata;
  logic          slot_re, slot_we, nxt_we;
  logic [SW-1:0] slot_raddr, slot_waddr, nxt_waddr;
  logic [PW-1:0] nxt_wdata;
  logic          stk_re, stk_we;
  logic [SW-1:0] stk_raddr, stk_waddr, stk_wdata;

  logic [HW-1:0] bidx;
  logic [PW-1:0] head_eff;
  logic          is_del;
  logic [SW-1:0] ins_slot;
  logic          do_ins;
  logic [PW:0]   step_nx;
  logic [PW-1:0] fcnt_m1;

  assign bidx     = op_q.bkt[HW-1:0];
  assign head_eff = head_vld_q[bidx] ? head_rd_q : Nil;
  assign is_del   = (op_q.func == OpDelete);
  assign step_nx  = {1'b0, step_q} + {{PW{1'b0}}, 1'b1};
  assign fcnt_m1  = fcnt_q - {{(PW-1){1'b0}}, 1'b1};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    step_d      = step_q;
    fcnt_d      = fcnt_q;
    fresh_d     = fresh_q;
    res_vld_d   = 1'b0;
    res_found_d = res_found_q;
    res_rv_d    = res_rv_q;
    res_st_d    = res_st_q;
    pop_o       = 1'b0;
    head_re     = 1'b0;
    head_raddr  = req_i.bkt[HW-1:0];
    head_we     = 1'b0;
    head_waddr  = bidx;
    head_wdata  = Nil;
    slot_re     = 1'b0;
    slot_raddr  = head_eff[SW-1:0];
    slot_we     = 1'b0;
    slot_waddr  = '0;
    nxt_we      = 1'b0;
    nxt_waddr   = '0;
    nxt_wdata   = head_eff;
    stk_re      = 1'b0;
    stk_raddr   = fcnt_m1[SW-1:0];
    stk_we      = 1'b0;
    stk_waddr   = fcnt_q[SW-1:0];
    stk_wdata   = cur_q[SW-1:0];
    ins_slot    = stk_rd_q;
    do_ins      = 1'b0;
    case (state_q)
      BIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          op_d    = req_i;
          head_re = 1'b1;
          state_d = BHead;
        end
      end
      BHead: begin
        if (op_q.func == OpInsert) begin
          if (fcnt_q != '0) begin
            // reuse a freed slot from the stack
            stk_re  = 1'b1;
            fcnt_d  = fcnt_m1;
            state_d = BPop;
          end else if (fresh_q != Nil) begin
            ins_slot = fresh_q[SW-1:0];
            fresh_d  = fresh_q + {{(PW-1){1'b0}}, 1'b1};
            do_ins   = 1'b1;
          end else begin
            res_vld_d   = 1'b1;
            res_found_d = 1'b0;
            res_rv_d    = 32'd0;
            res_st_d    = StFull;
            state_d     = BIdle;
          end
        end else if (head_eff == Nil) begin
          res_vld_d   = 1'b1;
          res_found_d = 1'b0;
          res_rv_d    = is_del ? 32'd0 : 32'hFFFF_FFFF;
          res_st_d    = StMiss;
          state_d     = BIdle;
        end else begin
          slot_re = 1'b1;
          cur_d   = head_eff;
          prev_d  = Nil;
          step_d  = '0;
          state_d = BWalk;
        end
      end
      BPop: begin
        do_ins = 1'b1;
      end
      BWalk: begin
        if (key_rd_q == op_q.key) begin
          res_vld_d   = 1'b1;
          res_found_d = 1'b1;
          res_st_d    = StDone;
          res_rv_d    = is_del ? 32'd0 : val_rd_q;
          state_d     = BIdle;
          if (is_del) begin
            // unlink the node and return its slot to the stack
            if (prev_q == Nil) begin
              head_we    = 1'b1;
              head_wdata = nxt_rd_q;
            end else begin
              nxt_we    = 1'b1;
              nxt_waddr = prev_q[SW-1:0];
              nxt_wdata = nxt_rd_q;
            end
            if (fcnt_q < fresh_q) begin
              stk_we = 1'b1;
              fcnt_d = fcnt_q + {{(PW-1){1'b0}}, 1'b1};
            end
          end
        end else if (step_nx >= (PW+1)'(PoolSlots) || nxt_rd_q == Nil) begin
          res_vld_d   = 1'b1;
          res_found_d = 1'b0;
          res_rv_d    = is_del ? 32'd0 : 32'hFFFF_FFFF;
          res_st_d    = StMiss;
          state_d     = BIdle;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = nxt_rd_q[SW-1:0];
          prev_d     = cur_q;
          cur_d      = nxt_rd_q;
          step_d     = step_nx[PW-1:0];
        end
      end
      default: state_d = BIdle;
    endcase
    if (do_ins) begin
      // link the new node at the head of its chain
      slot_we     = 1'b1;
      slot_waddr  = ins_slot;
      nxt_we      = 1'b1;
      nxt_waddr   = ins_slot;
      nxt_wdata   = head_eff;
      head_we     = 1'b1;
      head_wdata  = PW'(ins_slot);
      res_vld_d   = 1'b1;
      res_found_d = 1'b0;
      res_rv_d    = 32'd0;
      res_st_d    = StDone;
      state_d     = BIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BIdle;
      fcnt_q     <= '0;
      fresh_q    <= '0;
      head_vld_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      fcnt_q    <= fcnt_d;
      fresh_q   <= fresh_d;
      res_vld_q <= res_vld_d;
      if (head_we) head_vld_q[head_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    step_q      <= step_d;
    res_found_q <= res_found_d;
    res_rv_q    <= res_rv_d;
    res_st_q    <= res_st_d;
    if (res_vld_d) res_bkt_q <= op_q.bkt[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      key_mem[slot_waddr] <= op_q.key;
      val_mem[slot_waddr] <= op_q.value;
    end
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    if (slot_re) begin
      key_rd_q <= key_mem[slot_raddr];
      val_rd_q <= val_mem[slot_raddr];
      nxt_rd_q <= nxt_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_q <= stk_mem[stk_raddr];
  end

  assign valid_o      = res_vld_q;
  assign found_o      = res_found_q;
  assign read_value_o = res_rv_q;
  assign bucket_o     = res_bkt_q;
  assign status_o     = res_st_q;

  a_found_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_found_q |-> res_st_q == StDone)
    else $error("found result without done status");

  a_free_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= fresh_q)
    else $error("free stack holds more slots than were handed out");

  a_one_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q)
    else $error("back-to-back result beats");

endmodule

// File: hdl/chained_hash_dictionary_top.sv
// Top level of the chained hash dictionary.
// Ties the front end, the request queue and the back end; depends on cdh_pkg.
//
// Usage:
//   Command channel: drive func_i, key_i and value_i and raise start_i; the
//   beat is taken at a rising edge with start_i high and busy_o low. func_i
//   0 inserts, 1 deletes, 2 (and 3) looks up.
//   Result channel: every command yields one result beat, shown for exactly
//   one cycle with valid_o high; the receiver cannot stall, so capture it then.
// Sequencing:
//   The front end holds busy_o high through digit summing (FDig), the modulo
//   subtract loop (FMod) and the push (FPush), which waits while the queue is
//   full; it takes a new command while the back end still works on older ones.
//   The back end reads the bucket head (BHead), pops a freed slot (BPop) when
//   an insert reuses one, and walks the chain node by node (BWalk) for delete
//   or lookup; it takes one queued request at a time and registers its result.
// Reset:
//   rst_ni low empties every bucket and the free list; no clearing pass is
//   needed, the block takes commands right after reset.
module chained_hash_dictionary_top #(
  parameter int unsigned Buckets   = cdh_pkg::DefBuckets,
  parameter int unsigned PoolSlots = cdh_pkg::DefPoolSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        valid_o,
  output logic        found_o,
  output logic [31:0] read_value_o,
  output logic [3:0]  bucket_o,
  output logic [1:0]  status_o
);
  import cdh_pkg::*;

  // front end to queue
  req_t fq_req, qb_req;
  logic fq_push, fq_full;
  // queue to back end
  logic qb_empty, qb_pop;

  cdh_front #(.Buckets(Buckets)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .key_i   (key_i),
    .value_i (value_i),
    .busy_o  (busy_o),
    .full_i  (fq_full),
    .push_o  (fq_push),
    .req_o   (fq_req)
  );

  // decouple hashing from chain walking
  cdh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .req_i   (fq_req),
    .full_o  (fq_full),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .req_o   (qb_req)
  );

  cdh_back #(.Buckets(Buckets), .PoolSlots(PoolSlots)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (qb_empty),
    .req_i        (qb_req),
    .pop_o        (qb_pop),
    .valid_o      (valid_o),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .bucket_o     (bucket_o),
    .status_o     (status_o)
  );

endmodule
